@@ sv/spq_pkg.sv @@
// Shared types, codes and constants for the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

	localparam int KEY_W     = 32;
	localparam int DEPTH_DEF = 16;
	localparam int TAG_W_DEF = 16;
	localparam int REQ_W     = 2;
	localparam int STS_W     = 2;

	// request codes
	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

	// status codes
	localparam logic [STS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
	localparam logic [STS_W-1:0] STS_EMPTY = 2'd2;

	typedef enum logic [2:0] {
		CTL_IDLE,
		CTL_INS_CHK,
		CTL_INS_CMP,
		CTL_REM,
		CTL_RESP
	} ctl_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic             cap;      // latch request word, start insert position at tail
		logic             rd_ins;   // read entry just ahead of insert position
		logic             shift_wr; // move read entry back one slot
		logic             put_wr;   // write new entry at insert position
		logic             rd_front; // read front entry
		logic             pop;      // drop front entry, report it
		logic             clr;      // empty the queue
		logic             resp;     // load result registers
		logic [STS_W-1:0] status;
	} spq_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic empty;
		logic full;
		logic pos_zero;
		logic rd_gt;
	} spq_stat_t;

endpackage

`default_nettype wire

@@ sv/spq_ctrl.sv @@
// Controller state machine of the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl
	import spq_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  wire logic [REQ_W-1:0] req_type,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output spq_cmd_t              cmd,
	input  wire spq_stat_t        stat
);

	ctl_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CTL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.status = STS_OK;
		req_stall = (state_q != CTL_IDLE);
		rsp_valid = (state_q == CTL_RESP);
		case (state_q)
			CTL_IDLE: begin
				if (req_valid) begin
					cmd.cap = 1'b1;
					case (req_type)
						REQ_INSERT: begin
							if (stat.full) begin
								cmd.resp   = 1'b1;
								cmd.status = STS_FULL;
								state_d    = CTL_RESP;
							end else begin
								state_d = CTL_INS_CHK;
							end
						end
						REQ_REMOVE: begin
							if (stat.empty) begin
								cmd.resp   = 1'b1;
								cmd.status = STS_EMPTY;
								state_d    = CTL_RESP;
							end else begin
								cmd.rd_front = 1'b1;
								state_d      = CTL_REM;
							end
						end
						REQ_CLEAR: begin
							cmd.clr  = 1'b1;
							cmd.resp = 1'b1;
							state_d  = CTL_RESP;
						end
						default: begin
							// unused code: no change, plain ok result
							cmd.resp = 1'b1;
							state_d  = CTL_RESP;
						end
					endcase
				end
			end
			CTL_INS_CHK: begin
				if (stat.pos_zero) begin
					cmd.put_wr = 1'b1;
					cmd.resp   = 1'b1;
					state_d    = CTL_RESP;
				end else begin
					cmd.rd_ins = 1'b1;
					state_d    = CTL_INS_CMP;
				end
			end
			CTL_INS_CMP: begin
				// larger key ahead moves back; equal keys stay ahead
				if (stat.rd_gt) begin
					cmd.shift_wr = 1'b1;
					state_d      = CTL_INS_CHK;
				end else begin
					cmd.put_wr = 1'b1;
					cmd.resp   = 1'b1;
					state_d    = CTL_RESP;
				end
			end
			CTL_REM: begin
				cmd.pop  = 1'b1;
				cmd.resp = 1'b1;
				state_d  = CTL_RESP;
			end
			CTL_RESP: begin
				if (!rsp_stall) begin
					state_d = CTL_IDLE;
				end
			end
			default: begin
				state_d = CTL_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ sv/spq_dpath.sv @@
// Datapath of the sorted priority queue: entry memory, pointers and result registers.
`timescale 1ns / 1ps
`default_nettype none

module spq_dpath
	import spq_pkg::*;
#(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int TAG_WIDTH = TAG_W_DEF,
	parameter int AW        = $clog2(DEPTH),
	parameter int CW        = $clog2(DEPTH + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [KEY_W-1:0]     key,
	input  wire logic [TAG_WIDTH-1:0] payload_tag,
	input  wire spq_cmd_t             cmd,
	output spq_stat_t                 stat,
	output logic                      removed_valid,
	output logic [KEY_W-1:0]          removed_key,
	output logic [TAG_WIDTH-1:0]      removed_tag,
	output logic [CW-1:0]             occupancy,
	output logic                      is_empty,
	output logic [STS_W-1:0]          status
);

	localparam logic [AW:0]   DEPTH_X  = (AW + 1)'(DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	// entry memory, circular with front at head_q
	logic [KEY_W-1:0]     key_mem [DEPTH];
	logic [TAG_WIDTH-1:0] tag_mem [DEPTH];

	logic [AW-1:0]        head_q, head_d;
	logic [CW-1:0]        count_q, count_d;
	logic [AW-1:0]        pos_q;
	logic [KEY_W-1:0]     key_q;
	logic [TAG_WIDTH-1:0] tag_q;
	logic [KEY_W-1:0]     rd_key_q;
	logic [TAG_WIDTH-1:0] rd_tag_q;

	logic [AW-1:0]        wr_addr, rd_addr, ins_rd_addr;
	logic                 wr_en, rd_en;
	logic [KEY_W-1:0]     wr_key;
	logic [TAG_WIDTH-1:0] wr_tag;

	// logical slot to physical address, sum stays below twice the depth
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
		input logic [AW-1:0] off);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= DEPTH_X) begin
			sum = sum - DEPTH_X;
		end
		return sum[AW-1:0];
	endfunction

	assign stat.empty    = (count_q == '0);
	assign stat.full     = (count_q == FULL_CNT);
	assign stat.pos_zero = (pos_q == '0);
	assign stat.rd_gt    = (rd_key_q > key_q);

	// memory port selection
	assign ins_rd_addr = phys(head_q, pos_q - AW'(1));
	assign rd_en       = cmd.rd_ins | cmd.rd_front;
	assign rd_addr     = cmd.rd_front ? head_q : ins_rd_addr;
	assign wr_en       = cmd.shift_wr | cmd.put_wr;
	assign wr_addr     = phys(head_q, pos_q);
	assign wr_key      = cmd.shift_wr ? rd_key_q : key_q;
	assign wr_tag      = cmd.shift_wr ? rd_tag_q : tag_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			tag_mem[wr_addr] <= wr_tag;
		end
		if (rd_en) begin
			rd_key_q <= key_mem[rd_addr];
			rd_tag_q <= tag_mem[rd_addr];
		end
	end

	// next count and head
	always_comb begin
		count_d = count_q;
		head_d  = head_q;
		if (cmd.clr) begin
			count_d = '0;
		end else if (cmd.put_wr) begin
			count_d = count_q + CW'(1);
		end else if (cmd.pop) begin
			count_d = count_q - CW'(1);
			head_d  = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			head_q  <= '0;
		end else begin
			count_q <= count_d;
			head_q  <= head_d;
		end
	end

	// request word and insert position
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			key_q <= key;
			tag_q <= payload_tag;
			pos_q <= count_q[AW-1:0];
		end else if (cmd.shift_wr) begin
			pos_q <= pos_q - AW'(1);
		end
	end

	// result registers, held while the word waits
	always_ff @(posedge clk) begin
		if (cmd.resp) begin
			removed_valid <= cmd.pop;
			removed_key   <= cmd.pop ? rd_key_q : '0;
			removed_tag   <= cmd.pop ? rd_tag_q : '0;
			occupancy     <= count_d;
			is_empty      <= (count_d == '0);
			status        <= cmd.status;
		end
	end

endmodule

`default_nettype wire

@@ sv/sorted_priority_queue.sv @@
// Top level of the sorted priority queue: controller plus datapath.
// Usage:
//   Request channel (req_valid/req_stall) carries req_type, key and payload_tag.
//   req_type: insert, remove front, clear; the unused code leaves the queue as is.
//   Result channel (rsp_valid/rsp_stall) gives one word per request: removed
//   entry (zero if none), occupancy, is_empty and status.
//   Entries leave smallest key first; equal keys leave in arrival order.
// Sequence (request accepted to result valid):
//   insert: each stored entry with a larger key is moved one slot back through the
//     entry memory (read, then compare and write) before the new entry is written;
//     when every stored key is larger, as in an empty queue, no final compare is made.
//   insert when full, clear, unused code, remove when empty: result loaded on acceptance.
//   remove: front read from a circular buffer, then dropped; no shifting.
//   One request is in work at a time; req_stall stays high from acceptance
//   until the result word is taken, so the next request is taken in the cycle after that.
// Reset: arst_n empties the queue at once; no clearing pass is needed.
// Receiver stall: the result word holds steady while rsp_stall is high, and
//   req_stall stays high meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int TAG_WIDTH = TAG_W_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire logic [REQ_W-1:0]              req_type,
	input  wire logic [KEY_W-1:0]              key,
	input  wire logic [TAG_WIDTH-1:0]          payload_tag,
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output logic                               removed_valid,
	output logic [KEY_W-1:0]                   removed_key,
	output logic [TAG_WIDTH-1:0]               removed_tag,
	output logic [$clog2(DEPTH + 1)-1:0]       occupancy,
	output logic                               is_empty,
	output logic [STS_W-1:0]                   status
);

	spq_cmd_t  cmd;
	spq_stat_t stat;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	spq_dpath #(
		.DEPTH     (DEPTH),
		.TAG_WIDTH (TAG_WIDTH),
		.AW        ($clog2(DEPTH)),
		.CW        ($clog2(DEPTH + 1))
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.key           (key),
		.payload_tag   (payload_tag),
		.cmd           (cmd),
		.stat          (stat),
		.removed_valid (removed_valid),
		.removed_key   (removed_key),
		.removed_tag   (removed_tag),
		.occupancy     (occupancy),
		.is_empty      (is_empty),
		.status        (status)
	);

endmodule

`default_nettype wire

@@ tb/spq_order_checker.sv @@
// Checker for the sorted priority queue: tracks queue contents and compares every result word.
`timescale 1ns / 1ps

module spq_order_checker
	import spq_pkg::*;
#(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int TAG_WIDTH = TAG_W_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	input  logic                         req_stall,
	input  logic [REQ_W-1:0]             req_type,
	input  logic [KEY_W-1:0]             key,
	input  logic [TAG_WIDTH-1:0]         payload_tag,
	input  logic                         rsp_valid,
	input  logic                         rsp_stall,
	input  logic                         removed_valid,
	input  logic [KEY_W-1:0]             removed_key,
	input  logic [TAG_WIDTH-1:0]         removed_tag,
	input  logic [$clog2(DEPTH + 1)-1:0] occupancy,
	input  logic                         is_empty,
	input  logic [STS_W-1:0]             status,
	output int                           fail_count,
	output int                           results_owed
);

	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic                 removed_valid;
		logic [KEY_W-1:0]     removed_key;
		logic [TAG_WIDTH-1:0] removed_tag;
		logic [OCC_W-1:0]     occupancy;
		logic                 is_empty;
		logic [STS_W-1:0]     status;
	} queue_result_t;

	// shadow copy of the sorted entries, slot 0 is the front
	logic [KEY_W-1:0]     key_mem [DEPTH];
	logic [TAG_WIDTH-1:0] tag_mem [DEPTH];
	int                   entry_cnt;

	queue_result_t pending_results [$];
	queue_result_t got_word;
	queue_result_t want_word;

	// apply one request to the shadow queue and return the word it should produce
	function automatic queue_result_t next_queue_result(
		input logic [REQ_W-1:0]     kind,
		input logic [KEY_W-1:0]     new_key,
		input logic [TAG_WIDTH-1:0] new_tag
	);
		queue_result_t r;
		int pos;
		r = '0;
		r.status = STS_OK;
		case (kind)
			REQ_INSERT: begin
				if (entry_cnt >= DEPTH) begin
					r.status = STS_FULL;
				end else begin
					// new entry goes behind every key less than or equal to it
					pos = 0;
					while (pos < entry_cnt && key_mem[pos] <= new_key)
						pos++;
					for (int i = entry_cnt; i > pos; i--) begin
						key_mem[i] = key_mem[i-1];
						tag_mem[i] = tag_mem[i-1];
					end
					key_mem[pos] = new_key;
					tag_mem[pos] = new_tag;
					entry_cnt++;
				end
			end
			REQ_REMOVE: begin
				if (entry_cnt == 0) begin
					r.status = STS_EMPTY;
				end else begin
					r.removed_valid = 1'b1;
					r.removed_key   = key_mem[0];
					r.removed_tag   = tag_mem[0];
					for (int i = 1; i < entry_cnt; i++) begin
						key_mem[i-1] = key_mem[i];
						tag_mem[i-1] = tag_mem[i];
					end
					entry_cnt--;
				end
			end
			REQ_CLEAR: begin
				entry_cnt = 0;
			end
			default: begin
				// unused code leaves the queue alone
			end
		endcase
		r.occupancy = OCC_W'(entry_cnt);
		r.is_empty  = (entry_cnt == 0);
		return r;
	endfunction

	// watch both channels; results are checked before the request of the same edge is queued
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_cnt = 0;
			fail_count = 0;
			pending_results.delete();
			results_owed <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				got_word = {removed_valid, removed_key, removed_tag, occupancy, is_empty, status};
				if (pending_results.size() == 0) begin
					if (fail_count < REPORT_MAX)
						$display("%0t: unexpected result word rv=%0d key=%h tag=%h occ=%0d empty=%0d sts=%0d",
							$realtime, got_word.removed_valid, got_word.removed_key,
							got_word.removed_tag, got_word.occupancy, got_word.is_empty,
							got_word.status);
					fail_count = fail_count + 1;
				end else begin
					want_word = pending_results.pop_front();
					if (got_word !== want_word) begin
						if (fail_count < REPORT_MAX) begin
							$display("%0t: mismatch expected rv=%0d key=%h tag=%h occ=%0d empty=%0d sts=%0d",
								$realtime, want_word.removed_valid, want_word.removed_key,
								want_word.removed_tag, want_word.occupancy, want_word.is_empty,
								want_word.status);
							$display("%0t:          actual   rv=%0d key=%h tag=%h occ=%0d empty=%0d sts=%0d",
								$realtime, got_word.removed_valid, got_word.removed_key,
								got_word.removed_tag, got_word.occupancy, got_word.is_empty,
								got_word.status);
						end
						fail_count = fail_count + 1;
					end
				end
			end
			if (req_valid && !req_stall)
				pending_results.push_back(next_queue_result(req_type, key, payload_tag));
			results_owed <= pending_results.size();
		end
	end

endmodule

@@ tb/tb_sorted_priority_queue.sv @@
// Testbench top for the sorted priority queue: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
	import spq_pkg::*;

	localparam int DEPTH  = DEPTH_DEF;
	localparam int TAG_W  = TAG_W_DEF;
	localparam int OCC_W  = $clog2(DEPTH + 1);

	// request code with no defined action
	localparam logic [REQ_W-1:0] REQ_NOP = 2'd3;

	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int TAIL_CYCLES    = 40;

	typedef enum logic [2:0] {
		MODE_FREE,
		MODE_SEND_IDLE,
		MODE_RECV_STALL,
		MODE_BOTH,
		MODE_HOLD
	} idle_mode_t;

	logic               clk;
	logic               arst_n      = 1'b0;
	logic               req_valid   = 1'b0;
	logic               req_stall;
	logic [REQ_W-1:0]   req_type    = REQ_INSERT;
	logic [KEY_W-1:0]   key         = '0;
	logic [TAG_W-1:0]   payload_tag = '0;
	logic               rsp_valid;
	logic               rsp_stall   = 1'b0;
	logic               removed_valid;
	logic [KEY_W-1:0]   removed_key;
	logic [TAG_W-1:0]   removed_tag;
	logic [OCC_W-1:0]   occupancy;
	logic               is_empty;
	logic [STS_W-1:0]   status;

	int         fail_count;
	int         results_owed;
	idle_mode_t mode = MODE_FREE;
	int         gap_pct = 0;
	int         idle_cycles = 0;

	sorted_priority_queue #(
		.DEPTH     (DEPTH),
		.TAG_WIDTH (TAG_W)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req_type      (req_type),
		.key           (key),
		.payload_tag   (payload_tag),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.removed_valid (removed_valid),
		.removed_key   (removed_key),
		.removed_tag   (removed_tag),
		.occupancy     (occupancy),
		.is_empty      (is_empty),
		.status        (status)
	);

	spq_order_checker #(
		.DEPTH     (DEPTH),
		.TAG_WIDTH (TAG_W)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req_type      (req_type),
		.key           (key),
		.payload_tag   (payload_tag),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.removed_valid (removed_valid),
		.removed_key   (removed_key),
		.removed_tag   (removed_tag),
		.occupancy     (occupancy),
		.is_empty      (is_empty),
		.status        (status),
		.fail_count    (fail_count),
		.results_owed  (results_owed)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog: stretch of cycles with no word moving on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// result side: random stall per phase, one long hold when the hold phase starts
	initial begin : recv_proc
		int         hold_left;
		idle_mode_t last_mode;
		int         stall_pct;
		hold_left = 0;
		last_mode = MODE_FREE;
		forever begin
			@(posedge clk);
			if (mode == MODE_HOLD && last_mode != MODE_HOLD)
				hold_left = HOLD_CYCLES;
			last_mode = mode;
			case (mode)
				MODE_RECV_STALL: stall_pct = 87;
				MODE_BOTH:       stall_pct = 7;
				default:         stall_pct = 0;
			endcase
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	task automatic set_phase(input idle_mode_t m);
		mode <= m;
		case (m)
			MODE_SEND_IDLE: gap_pct = 87;
			MODE_BOTH:      gap_pct = 7;
			default:        gap_pct = 0;
		endcase
	endtask

	// offer one request word, optionally after an idle gap, and wait for acceptance
	task automatic send_word(
		input logic [REQ_W-1:0] kind,
		input logic [KEY_W-1:0] k,
		input logic [TAG_W-1:0] t
	);
		while ($urandom_range(0, 99) < gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid   <= 1'b1;
		req_type    <= kind;
		key         <= k;
		payload_tag <= t;
		do
			@(posedge clk);
		while (req_stall);
	endtask

	// sender pause until every result word has come back
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
	endtask

	// keys: dense small values for ties, values up to 1000, the top end, and full range
	function automatic logic [KEY_W-1:0] random_key();
		logic [KEY_W-1:0] k;
		case ($urandom_range(0, 3))
			0:       k = $urandom_range(0, 7);
			1:       k = 32'hFFFF_FFFF - $urandom_range(0, 3);
			2:       k = $urandom_range(0, 1000);
			default: k = $urandom;
		endcase
		return k;
	endfunction

	// random requests in bursts that lean toward filling, draining or neither
	task automatic run_random(input int n);
		logic [REQ_W-1:0] kind;
		int               ins_limit;
		int               burst_left;
		int               roll;
		burst_left = 0;
		ins_limit  = 55;
		for (int i = 0; i < n; i++) begin
			if (burst_left == 0) begin
				case ($urandom_range(0, 2))
					0:       ins_limit = 85;
					1:       ins_limit = 25;
					default: ins_limit = 55;
				endcase
				burst_left = $urandom_range(4, 40);
			end
			burst_left--;
			roll = $urandom_range(0, 99);
			if (roll < 3)
				kind = REQ_CLEAR;
			else if (roll < 6)
				kind = REQ_NOP;
			else if (roll < ins_limit)
				kind = REQ_INSERT;
			else
				kind = REQ_REMOVE;
			send_word(kind, random_key(), TAG_W'($urandom));
		end
	endtask

	initial begin : stimulus
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_phase(MODE_FREE);

		// directed: empty-queue corner cases, extremes, ties, full queue
		send_word(REQ_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
		send_word(REQ_NOP, 32'h1234_5678, 16'h00FF);
		send_word(REQ_CLEAR, '0, '0);
		send_word(REQ_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
		send_word(REQ_INSERT, 32'h0000_0000, 16'h0000);
		send_word(REQ_INSERT, 32'd7, 16'h0001);
		send_word(REQ_INSERT, 32'd7, 16'h0002);
		send_word(REQ_INSERT, 32'd7, 16'h0003);
		for (int i = 0; i < DEPTH - 5; i++)
			send_word(REQ_INSERT, KEY_W'(i * 3), TAG_W'(16'h0100 + i));
		send_word(REQ_INSERT, 32'd1, 16'hBEEF);
		send_word(REQ_NOP, 32'd2, 16'h0000);
		send_word(REQ_REMOVE, '0, '0);
		send_word(REQ_REMOVE, '0, '0);
		send_word(REQ_CLEAR, '0, '0);
		send_word(REQ_REMOVE, '0, '0);
		wait_drained();

		// random phases with different flow control
		run_random(400);
		wait_drained();
		set_phase(MODE_SEND_IDLE);
		run_random(300);
		wait_drained();
		set_phase(MODE_RECV_STALL);
		run_random(300);
		wait_drained();
		set_phase(MODE_BOTH);
		run_random(400);
		wait_drained();
		set_phase(MODE_HOLD);
		run_random(40);
		wait_drained();
		set_phase(MODE_FREE);
		run_random(260);

		// let everything drain, then give the verdict
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && results_owed == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
